// ===== rtl/kmh_pkg.sv =====
// Shared types, sizes and codes of the k-way merge heap core.
`default_nettype none

package kmh_pkg;

  // Heap size, the index widths that follow from it, and the key, run and status widths.
  localparam int WAYS   = 8;
  localparam int IDX_W  = $clog2(WAYS);
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int KID_W  = IDX_W + 2;
  localparam int KEY_W  = 64;
  localparam int RUN_W  = 3;
  localparam int STAT_W = 2;

  // Operation codes on the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // Status codes of a result word.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // One heap entry: the head key of a run and the run index.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [RUN_W-1:0]        run;
  } pair_t;

  // Write port of the heap memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    pair_t            data;
  } ram_wr_t;

endpackage

`default_nettype wire

// ===== rtl/kway_merge_heap_core.sv =====
// Top level of the k-way merge heap core: sequencer around heap memory and comparator.
//
// Input channel (in_valid/in_ready) takes one word: func, key, run, has_key.
// func insert pushes (key, run) into the min-heap; func pop optionally pushes
// the refill pair (has_key) and then removes the smallest pair.
// Output channel (out_valid/out_ready) returns one word per input word:
// min_key, min_run, valid_res, last and status.
// A rejected insert or a pop on an empty heap goes straight to the output
// step; a pop first reads the top and last entries and is decided there when
// the heap empties or the refill is the smallest. An insert sifts up, checking
// for the root and then comparing with the parent at each level; a pop sifts
// down, checking for a leaf, picking the smaller child and comparing with it at
// each level. The new pair moves at most log2(WAYS) levels. The single comparator,
// used once per cycle, and the registered read of the heap memory set these steps.
// in_ready is high only while the sequencer is idle, so one word is in work at a
// time, and a new word is taken only after the last result has left the sequencer.
// If the receiver stalls, the sequencer holds the finished result until the
// output register frees up, and no new word is taken meanwhile.
// Reset empties the heap (count to zero) and drops out_valid. The heap memory
// itself is not cleared; only entries below the count are used.
`default_nettype none

module kway_merge_heap_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [kmh_pkg::KEY_W-1:0]  key,
  input  logic [kmh_pkg::RUN_W-1:0]         run,
  input  logic                              has_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [kmh_pkg::KEY_W-1:0]  min_key,
  output logic [kmh_pkg::RUN_W-1:0]         min_run,
  output logic                              valid_res,
  output logic                              last,
  output logic [kmh_pkg::STAT_W-1:0]        status
);
  import kmh_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TOP    = 3'd1;
  localparam logic [2:0] S_SD_CHK = 3'd2;
  localparam logic [2:0] S_SD_KID = 3'd3;
  localparam logic [2:0] S_SD_MOV = 3'd4;
  localparam logic [2:0] S_UP_CHK = 3'd5;
  localparam logic [2:0] S_UP_CMP = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  idx, idx_next;
  pair_t             mov, mov_next;
  pair_t             kid, kid_next;
  logic [IDX_W-1:0]  kid_idx, kid_idx_next;
  logic              refill, refill_next;

  pair_t             res_pair, res_pair_next;
  logic              res_valid, res_valid_next;
  logic              res_last, res_last_next;
  logic [STAT_W-1:0] res_status, res_status_next;

  ram_wr_t           wr;
  logic [IDX_W-1:0]  rd_addr_a, rd_addr_b;
  pair_t             rd_a, rd_b;
  pair_t             cmp_a, cmp_b;
  logic              cmp_less;

  pair_t             in_pair;
  logic              accept;
  logic              out_load;
  logic [KID_W-1:0]  left_pos, right_pos, cnt_ext;
  logic [IDX_W-1:0]  parent;
  logic [CNT_W-1:0]  count_dec;

  assign in_pair.key = key;
  assign in_pair.run = run;
  assign in_ready    = state == S_IDLE;
  assign accept      = in_valid && in_ready;
  assign out_load    = (state == S_OUT) && (!out_valid || out_ready);

  // Child and parent positions of the current hole.
  assign left_pos  = {1'b0, idx, 1'b1};
  assign right_pos = left_pos + KID_W'(1);
  assign cnt_ext   = KID_W'(count);
  assign parent    = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign count_dec = count - CNT_W'(1);

  kmh_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  kmh_cmp u_cmp (
    .a    (cmp_a),
    .b    (cmp_b),
    .less (cmp_less)
  );

  // Operand selection for the shared comparator and read addresses per state.
  always_comb begin
    cmp_a     = mov;
    cmp_b     = rd_a;
    rd_addr_a = '0;
    rd_addr_b = IDX_W'(count_dec);
    case (state)
      S_SD_CHK: begin
        rd_addr_a = left_pos[IDX_W-1:0];
        rd_addr_b = right_pos[IDX_W-1:0];
      end
      S_SD_KID: begin
        cmp_a = rd_b;
        cmp_b = rd_a;
      end
      S_SD_MOV: begin
        cmp_a = kid;
        cmp_b = mov;
      end
      S_UP_CHK: begin
        rd_addr_a = parent;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    mov_next        = mov;
    kid_next        = kid;
    kid_idx_next    = kid_idx;
    refill_next     = refill;
    res_pair_next   = res_pair;
    res_valid_next  = res_valid;
    res_last_next   = res_last;
    res_status_next = res_status;
    wr              = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_pair_next   = '0;
          res_valid_next  = 1'b0;
          res_last_next   = 1'b0;
          res_status_next = ST_OK;
          mov_next        = in_pair;
          refill_next     = has_key;
          if (func == FUNC_INSERT) begin
            if (count >= CNT_W'(WAYS)) begin
              res_status_next = ST_FULL;
              state_next      = S_OUT;
            end else begin
              idx_next   = IDX_W'(count);
              count_next = count + CNT_W'(1);
              state_next = S_UP_CHK;
            end
          end else if (count == '0) begin
            if (has_key) begin
              res_pair_next  = in_pair;
              res_valid_next = 1'b1;
              res_last_next  = 1'b1;
            end else begin
              res_status_next = ST_EMPTY;
            end
            state_next = S_OUT;
          end else begin
            state_next = S_TOP;
          end
        end
      end
      // Top entry and last entry are now on the read ports.
      S_TOP: begin
        res_valid_next = 1'b1;
        idx_next       = '0;
        if (refill) begin
          if (cmp_less) begin
            res_pair_next = mov;
            state_next    = S_OUT;
          end else begin
            res_pair_next = rd_a;
            state_next    = S_SD_CHK;
          end
        end else begin
          res_pair_next = rd_a;
          count_next    = count_dec;
          mov_next      = rd_b;
          if (count_dec == '0) begin
            res_last_next = 1'b1;
            state_next    = S_OUT;
          end else begin
            state_next = S_SD_CHK;
          end
        end
      end
      // Sift down: stop at a leaf, else fetch both children.
      S_SD_CHK: begin
        if (left_pos >= cnt_ext) begin
          wr.en      = 1'b1;
          wr.addr    = idx;
          wr.data    = mov;
          state_next = S_OUT;
        end else begin
          state_next = S_SD_KID;
        end
      end
      S_SD_KID: begin
        if ((right_pos < cnt_ext) && cmp_less) begin
          kid_next     = rd_b;
          kid_idx_next = right_pos[IDX_W-1:0];
        end else begin
          kid_next     = rd_a;
          kid_idx_next = left_pos[IDX_W-1:0];
        end
        state_next = S_SD_MOV;
      end
      S_SD_MOV: begin
        wr.en   = 1'b1;
        wr.addr = idx;
        if (cmp_less) begin
          wr.data    = kid;
          idx_next   = kid_idx;
          state_next = S_SD_CHK;
        end else begin
          wr.data    = mov;
          state_next = S_OUT;
        end
      end
      // Sift up: stop at the root, else fetch the parent.
      S_UP_CHK: begin
        if (idx == '0) begin
          wr.en      = 1'b1;
          wr.addr    = idx;
          wr.data    = mov;
          state_next = S_OUT;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr.en   = 1'b1;
        wr.addr = idx;
        if (cmp_less) begin
          wr.data    = rd_a;
          idx_next   = parent;
          state_next = S_UP_CHK;
        end else begin
          wr.data    = mov;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Work registers of the sequencer.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    mov        <= mov_next;
    kid        <= kid_next;
    kid_idx    <= kid_idx_next;
    refill     <= refill_next;
    res_pair   <= res_pair_next;
    res_valid  <= res_valid_next;
    res_last   <= res_last_next;
    res_status <= res_status_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      min_key   <= res_pair.key;
      min_run   <= res_pair.run;
      valid_res <= res_valid;
      last      <= res_last;
      status    <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kmh_ram.sv =====
// Heap storage: one write port and two read ports with registered read data.
`default_nettype none

module kmh_ram (
  input  logic                     clk,
  input  kmh_pkg::ram_wr_t         wr,
  input  logic [kmh_pkg::IDX_W-1:0] rd_addr_a,
  input  logic [kmh_pkg::IDX_W-1:0] rd_addr_b,
  output kmh_pkg::pair_t           rd_data_a,
  output kmh_pkg::pair_t           rd_data_b
);
  import kmh_pkg::*;

  pair_t mem [WAYS];

  // Write first in program order; reads return the contents before this edge.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/kmh_cmp.sv =====
// Shared pair comparator: signed key first, lower run index wins a tie.
`default_nettype none

module kmh_cmp (
  input  kmh_pkg::pair_t a,
  input  kmh_pkg::pair_t b,
  output logic           less
);
  import kmh_pkg::*;

  logic key_lt;
  logic key_eq;

  // One signed key compare plus a key equality and a run compare for the tie break.
  assign key_lt = $signed(a.key) < $signed(b.key);
  assign key_eq = a.key == b.key;
  assign less   = key_lt || (key_eq && (a.run < b.run));

endmodule

`default_nettype wire

// ===== rtl/kmh_checker.sv =====
// Port-level checks of the k-way merge heap core, bound to the top level.
`default_nettype none

module kmh_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [kmh_pkg::KEY_W-1:0]  min_key,
  input logic [kmh_pkg::RUN_W-1:0]         min_run,
  input logic                              valid_res,
  input logic                              last,
  input logic [kmh_pkg::STAT_W-1:0]        status
);
  import kmh_pkg::*;

  // A word that reports an error carries no popped entry.
  a_err_no_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> !valid_res)
    else $error("error status with valid_res set");

  // An empty heap after a pop can only follow a real pop.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> valid_res && (status == ST_OK))
    else $error("last set without a popped entry");

  // A word without an entry shows zero key and run.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> (min_key == '0) && (min_run == '0))
    else $error("nonzero key or run without an entry");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(min_key) && $stable(status))
    else $error("output word changed while stalled");

  // Taking a word drops in_ready.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted before the first finished");

endmodule

bind kway_merge_heap_core kmh_checker u_kmh_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the k-way merge heap core: directed cases, merges, noise, pressure.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kmh_pkg::*;

  localparam int  HOLD_CYCLES  = 300;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT  = 120000;
  localparam int  MAX_REPORTS  = 10;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;

  // One result word as the block returns it.
  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    logic [RUN_W-1:0]        min_run;
    logic                    valid_res;
    logic                    last;
    logic [STAT_W-1:0]       status;
  } merge_res_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     func      = FUNC_INSERT;
  logic signed [KEY_W-1:0]  key       = '0;
  logic [RUN_W-1:0]         run       = '0;
  logic                     has_key   = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [KEY_W-1:0]  min_key;
  logic [RUN_W-1:0]         min_run;
  logic                     valid_res;
  logic                     last;
  logic [STAT_W-1:0]        status;

  // Shadow heap of the predictor.
  pair_t      shadow_heap [WAYS];
  int         shadow_fill = 0;
  merge_res_t pending_results [$];
  merge_res_t latest_result;

  int  words_sent  = 0;
  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  quiet       = 1'b0;
  bit  hold_req    = 1'b0;

  kway_merge_heap_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .key       (key),
    .run       (run),
    .has_key   (has_key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_key   (min_key),
    .min_run   (min_run),
    .valid_res (valid_res),
    .last      (last),
    .status    (status)
  );

  always #5 clk = ~clk;

  // Order of heap pairs: signed key first, lower run wins a tie.
  function automatic logic pair_before(pair_t a, pair_t b);
    if (a.key != b.key) return $signed(a.key) < $signed(b.key);
    return a.run < b.run;
  endfunction

  function automatic void heap_swap(int i, int j);
    pair_t t;
    t = shadow_heap[i];
    shadow_heap[i] = shadow_heap[j];
    shadow_heap[j] = t;
  endfunction

  function automatic void heap_bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!pair_before(shadow_heap[i], shadow_heap[p])) break;
      heap_swap(i, p);
      i = p;
    end
  endfunction

  function automatic void heap_trickle_down(int i);
    int l;
    int r;
    int m;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < shadow_fill && pair_before(shadow_heap[l], shadow_heap[m])) m = l;
      if (r < shadow_fill && pair_before(shadow_heap[r], shadow_heap[m])) m = r;
      if (m == i) break;
      heap_swap(i, m);
      i = m;
    end
  endfunction

  // Apply one accepted word to the shadow heap and return the result word it causes.
  function automatic merge_res_t predict_word(logic f, logic signed [KEY_W-1:0] k,
                                              logic [RUN_W-1:0] r, logic hk);
    merge_res_t res;
    pair_t      np;
    res = '0;
    res.status = ST_OK;
    np.key = k;
    np.run = r;
    if (f == FUNC_INSERT) begin
      if (shadow_fill >= WAYS) begin
        res.status = ST_FULL;
      end else begin
        shadow_heap[shadow_fill] = np;
        shadow_fill++;
        heap_bubble_up(shadow_fill - 1);
      end
    end else if (hk) begin
      // The refill joins first, so it can leave at once when it is the smallest.
      res.valid_res = 1'b1;
      if (shadow_fill == 0 || pair_before(np, shadow_heap[0])) begin
        res.min_key = k;
        res.min_run = r;
      end else begin
        res.min_key = shadow_heap[0].key;
        res.min_run = shadow_heap[0].run;
        shadow_heap[0] = np;
        heap_trickle_down(0);
      end
      res.last = (shadow_fill == 0);
    end else if (shadow_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.valid_res = 1'b1;
      res.min_key = shadow_heap[0].key;
      res.min_run = shadow_heap[0].run;
      shadow_fill--;
      if (shadow_fill > 0) begin
        shadow_heap[0] = shadow_heap[shadow_fill];
        heap_trickle_down(0);
      end
      res.last = (shadow_fill == 0);
    end
    return res;
  endfunction

  // Keys from the whole range, from narrow bands that give ties, and the extremes.
  function automatic logic signed [KEY_W-1:0] rand_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 5))
      0, 1: k = {$urandom, $urandom};
      2: k = longint'($urandom_range(0, 40)) - 20;
      3: begin
        case ($urandom_range(0, 3))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = '0;
          default: k = -64'sd1;
        endcase
      end
      default: k = longint'($urandom_range(0, 2000)) - 1000;
    endcase
    return k;
  endfunction

  // Next key of a sorted run: never below the previous one.
  function automatic logic signed [KEY_W-1:0] next_run_key(logic signed [KEY_W-1:0] prev);
    longint step;
    logic [KEY_W-1:0] wide;
    if ($urandom_range(0, 3) == 0) begin
      wide = {$urandom, $urandom};
      step = longint'(wide >> $urandom_range(1, 63));
    end else begin
      step = $urandom_range(0, 5);
    end
    if (prev > KEY_MAX - step) return KEY_MAX;
    return prev + step;
  endfunction

  // Offer one word, wait for its acceptance and record the result it will cause.
  task automatic send_word(logic f, logic signed [KEY_W-1:0] k, logic [RUN_W-1:0] r,
                           logic hk);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    key      <= k;
    run      <= r;
    has_key  <= hk;
    do @(posedge clk); while (!in_ready);
    latest_result = predict_word(f, k, r, hk);
    pending_results.insert(pending_results.size(), latest_result);
    words_sent++;
  endtask

  task automatic pop_word(logic signed [KEY_W-1:0] k, logic [RUN_W-1:0] r, logic hk);
    send_word(FUNC_POP, k, r, hk);
  endtask

  // One well-formed merge over distinct runs: prime, then pop with refills of the popped run.
  task automatic run_merge(int ways, int max_len);
    int                      order [8];
    int                      left [8];
    int                      j;
    int                      t;
    int                      pr;
    logic signed [KEY_W-1:0] pk;
    bit                      have_prev;
    for (int i = 0; i < 8; i++) order[i] = i;
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 8; i++) left[i] = 0;
    for (int i = 0; i < ways; i++) begin
      left[order[i]] = $urandom_range(1, max_len) - 1;
      send_word(FUNC_INSERT, rand_key(), order[i], $urandom_range(0, 1));
    end
    have_prev = 1'b0;
    pr = 0;
    pk = '0;
    do begin
      if (have_prev && left[pr] > 0) begin
        left[pr]--;
        pop_word(next_run_key(pk), pr, 1'b1);
      end else begin
        pop_word({$urandom, $urandom}, $urandom_range(0, 7), 1'b0);
      end
      pr = latest_result.min_run;
      pk = latest_result.min_key;
      have_prev = 1'b1;
    end while (!(latest_result.last && left[pr] == 0));
  endtask

  // Extremes, ties, full and empty heap, refills on a full and an empty heap.
  task automatic test_directed_cases();
    pop_word(KEY_MAX, 3'd4, 1'b0);
    pop_word(KEY_MIN, 3'd5, 1'b1);
    send_word(FUNC_INSERT, KEY_MAX, 3'd7, 1'b0);
    send_word(FUNC_INSERT, KEY_MIN, 3'd0, 1'b0);
    send_word(FUNC_INSERT, '0, 3'd3, 1'b1);
    send_word(FUNC_INSERT, -64'sd1, 3'd4, 1'b0);
    send_word(FUNC_INSERT, 64'sd5, 3'd6, 1'b0);
    send_word(FUNC_INSERT, 64'sd5, 3'd2, 1'b0);
    send_word(FUNC_INSERT, 64'sd5, 3'd2, 1'b1);
    send_word(FUNC_INSERT, 64'sd1, 3'd1, 1'b0);
    send_word(FUNC_INSERT, 64'sd9, 3'd5, 1'b1);
    pop_word(KEY_MIN, 3'd1, 1'b1);
    pop_word(KEY_MIN, 3'd0, 1'b1);
    pop_word(KEY_MAX, 3'd7, 1'b1);
    for (int i = 0; i < WAYS; i++) pop_word(~'0, 3'd7, 1'b0);
    pop_word('0, 3'd0, 1'b0);
  endtask

  task automatic test_random_merges();
    while (words_sent < 360) begin
      if ($urandom_range(0, 4) == 0) run_merge(WAYS, 8);
      else run_merge($urandom_range(1, WAYS), $urandom_range(1, 6));
    end
  endtask

  // Unstructured words: an insert-heavy half, a pop-heavy half, then a drain.
  task automatic test_noise();
    for (int i = 0; i < 120; i++) begin
      send_word(($urandom_range(0, 99) < (i < 60 ? 30 : 70)) ? FUNC_POP : FUNC_INSERT,
                rand_key(), $urandom_range(0, 7), $urandom_range(0, 1));
    end
    while (shadow_fill > 0) pop_word(rand_key(), $urandom_range(0, 7), 1'b0);
  endtask

  // Back-to-back words on both sides with no idle cycles.
  task automatic test_quiet_merge();
    quiet = 1'b1;
    run_merge(WAYS, 6);
    quiet = 1'b0;
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_output_hold();
    hold_req = 1'b1;
    run_merge(WAYS, 4);
  endtask

  // Receiver pacing, with one long hold-off on request.
  initial begin : rx_pacing
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (quiet || $urandom_range(0, 99) >= 8) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
      end
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    merge_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result word: key %0d run %0d valid %0b last %0b status %0d",
                   $signed(min_key), min_run, valid_res, last, status);
      end else begin
        want = pending_results.pop_front();
        if (min_key !== want.min_key || min_run !== want.min_run ||
            valid_res !== want.valid_res || last !== want.last ||
            status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch: expected key %0d run %0d valid %0b last %0b status %0d",
                     $signed(want.min_key), want.min_run, want.valid_res, want.last,
                     want.status);
            $display("          actual   key %0d run %0d valid %0b last %0b status %0d",
                     $signed(min_key), min_run, valid_res, last, status);
          end
        end
      end
    end
  end

  // Cycle limit on the whole run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main_sequence
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_merges();
    test_noise();
    test_quiet_merge();
    test_output_hold();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
